[design/etef_pkg.sv]
`default_nettype none
package etef_pkg;

  localparam int RING_SLOTS = 64;
  localparam int CHANNELS   = 8;

  localparam int RING_W   = $clog2(RING_SLOTS);
  localparam int CH_W     = 3;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TICK_W   = 64;
  localparam int SEQ_W    = 32;
  localparam int META_W   = CH_W + 1 + SEQ_W;

  typedef logic [RING_W-1:0] ring_idx_t;
  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [SEQ_W-1:0]  seq_t;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef struct packed {
    chan_t ch;
    logic  bump_seq;
    logic  bump_drop;
    logic  clear;
  } cnt_ctrl_t;

  typedef struct packed {
    seq_t channel_count;
    seq_t drop_count;
  } cnt_stat_t;

  function automatic ring_idx_t ring_next(input ring_idx_t i);
    return (i == RING_W'(RING_SLOTS - 1)) ? '0 : i + RING_W'(1);
  endfunction

  function automatic logic ch_in_range(input chan_t ch);
    return {1'b0, ch} < (CH_W + 1)'(CHANNELS);
  endfunction

endpackage
`default_nettype wire

[design/etef_if.sv]
`default_nettype none
interface etef_in_if;
  import etef_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic [CH_W-1:0]     edge_channel;
  logic                edge_level;
  logic [TICK_W-1:0]   edge_time;

  modport source (output valid, cmd, edge_channel, edge_level, edge_time, input ready);
  modport sink   (input valid, cmd, edge_channel, edge_level, edge_time, output ready);
endinterface

interface etef_out_if;
  import etef_pkg::*;
  logic                valid;
  logic                ready;
  logic                pop_valid;
  logic [CH_W-1:0]     out_channel;
  logic                out_level;
  logic [TICK_W-1:0]   out_tick;
  logic [SEQ_W-1:0]    out_seq;
  logic                edge_stored;
  logic [SEQ_W-1:0]    channel_count;
  logic [SEQ_W-1:0]    drop_count;

  modport source (output valid, pop_valid, out_channel, out_level, out_tick, out_seq,
                  edge_stored, channel_count, drop_count, input ready);
  modport sink   (input valid, pop_valid, out_channel, out_level, out_tick, out_seq,
                  edge_stored, channel_count, drop_count, output ready);
endinterface
`default_nettype wire

[design/etef_ram.sv]
`default_nettype none
module etef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[design/etef_counters.sv]
`default_nettype none
module etef_counters
  import etef_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cnt_ctrl_t ctrl,
  output      cnt_stat_t stat
);

  seq_t seq [CHANNELS];
  seq_t drop;
  logic [CH_IDX_W-1:0] idx;
  logic in_range;
  seq_t cur;

  assign idx      = ctrl.ch[CH_IDX_W-1:0];
  assign in_range = ch_in_range(ctrl.ch);
  assign cur      = in_range ? seq[idx] : '0;

  // values as they stand after this beat
  always_comb begin
    if (ctrl.clear) begin
      stat.channel_count = '0;
      stat.drop_count    = '0;
    end else begin
      stat.channel_count = cur + SEQ_W'(ctrl.bump_seq);
      stat.drop_count    = drop + SEQ_W'(ctrl.bump_drop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int i = 0; i < CHANNELS; i++) begin
        seq[i] <= '0;
      end
      drop <= '0;
    end else begin
      if (ctrl.bump_seq && in_range) begin
        seq[idx] <= stat.channel_count;
      end
      drop <= stat.drop_count;
    end
  end

endmodule
`default_nettype wire

[design/edge_timestamp_event_fifo_core.sv]
// Timestamped edge event FIFO. Each input beat carries one command: record an
// edge (channel, level, 64-bit tick), pop the oldest event, or clear all
// counters and the ring; each command yields exactly one result beat. Events
// live in two single-port-read ring memories (tick and channel/level/seq) of
// RING_SLOTS entries, RING_SLOTS-1 usable. Records, clears, unused commands and
// pops on an empty ring answer in S_IDLE; a popped event waits in S_READ for the
// registered ring memory read, taking no new beat. A finished result sits in an
// output register; the next command is accepted in the same cycle that result
// is taken. capture_enable is written through cfg_we/cfg_data while the block
// is idle; the user must ensure this, the block does not. No clearing pass is
// needed after reset: ring entries are only read after they were written.
`default_nettype none
module edge_timestamp_event_fifo_core
  import etef_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_data,
  etef_in_if.sink   evt,
  etef_out_if.source res
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t    state;
  logic      capture_enable;
  ring_idx_t wr_idx;
  ring_idx_t rd_idx;
  chan_t     pend_ch;

  logic accept, drain_ok, full, empty;
  logic do_rec, do_store, do_drop, do_pop, do_clear;
  cmd_t cmd;

  cnt_ctrl_t cnt_ctrl;
  cnt_stat_t cnt_stat;

  logic [TICK_W-1:0] tick_rd;
  logic [META_W-1:0] meta_rd;
  logic [META_W-1:0] meta_wr;

  // output register
  logic              o_valid;
  logic              o_pop_valid;
  chan_t             o_channel;
  logic              o_level;
  logic [TICK_W-1:0] o_tick;
  seq_t              o_seq;
  logic              o_stored;
  seq_t              o_ch_count;
  seq_t              o_drop_count;

  assign cmd      = cmd_t'(evt.cmd);
  assign drain_ok = !o_valid || res.ready;
  assign evt.ready = (state == S_IDLE) && drain_ok;
  assign accept   = evt.valid && evt.ready;

  assign full  = (ring_next(wr_idx) == rd_idx);
  assign empty = (rd_idx == wr_idx);

  assign do_rec   = accept && (cmd == CMD_RECORD) && capture_enable
                    && ch_in_range(evt.edge_channel);
  assign do_store = do_rec && !full;
  assign do_drop  = do_rec && full;
  assign do_pop   = accept && (cmd == CMD_POP) && !empty;
  assign do_clear = accept && (cmd == CMD_CLEAR);

  always_comb begin
    cnt_ctrl.ch        = (state == S_READ) ? pend_ch : evt.edge_channel;
    cnt_ctrl.bump_seq  = do_rec;
    cnt_ctrl.bump_drop = do_drop;
    cnt_ctrl.clear     = do_clear;
  end

  etef_counters u_counters (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cnt_ctrl),
    .stat (cnt_stat)
  );

  assign meta_wr = {evt.edge_channel, evt.edge_level, cnt_stat.channel_count};

  etef_ram #(.WIDTH(TICK_W), .DEPTH(RING_SLOTS)) u_tick_ram (
    .clk   (clk),
    .we    (do_store),
    .waddr (wr_idx),
    .wdata (evt.edge_time),
    .re    (do_pop),
    .raddr (rd_idx),
    .rdata (tick_rd)
  );

  etef_ram #(.WIDTH(META_W), .DEPTH(RING_SLOTS)) u_meta_ram (
    .clk   (clk),
    .we    (do_store),
    .waddr (wr_idx),
    .wdata (meta_wr),
    .re    (do_pop),
    .raddr (rd_idx),
    .rdata (meta_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable <= 1'b0;
    end else if (cfg_we) begin
      capture_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
    end else if (do_clear) begin
      wr_idx <= '0;
      rd_idx <= '0;
    end else begin
      if (do_store) begin
        wr_idx <= ring_next(wr_idx);
      end
      if (do_pop) begin
        rd_idx <= ring_next(rd_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (do_pop) begin
              pend_ch <= evt.edge_channel;
              state   <= S_READ;
              if (res.ready) begin
                o_valid <= 1'b0;
              end
            end else begin
              o_valid      <= 1'b1;
              o_pop_valid  <= 1'b0;
              o_channel    <= '0;
              o_level      <= 1'b0;
              o_tick       <= '0;
              o_seq        <= '0;
              o_stored     <= do_store;
              o_ch_count   <= cnt_stat.channel_count;
              o_drop_count <= cnt_stat.drop_count;
            end
          end else if (res.ready) begin
            o_valid <= 1'b0;
          end
        end
        S_READ: begin
          if (drain_ok) begin
            // ring read data is held until loaded here
            state        <= S_IDLE;
            o_valid      <= 1'b1;
            o_pop_valid  <= 1'b1;
            o_channel    <= meta_rd[META_W-1 -: CH_W];
            o_level      <= meta_rd[SEQ_W];
            o_tick       <= tick_rd;
            o_seq        <= meta_rd[SEQ_W-1:0];
            o_stored     <= 1'b0;
            o_ch_count   <= cnt_stat.channel_count;
            o_drop_count <= cnt_stat.drop_count;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid         = o_valid;
  assign res.pop_valid     = o_pop_valid;
  assign res.out_channel   = o_channel;
  assign res.out_level     = o_level;
  assign res.out_tick      = o_tick;
  assign res.out_seq       = o_seq;
  assign res.edge_stored   = o_stored;
  assign res.channel_count = o_ch_count;
  assign res.drop_count    = o_drop_count;

endmodule
`default_nettype wire

[dv/tb_edge_timestamp_event_fifo_core.sv]
`default_nettype none
module tb_edge_timestamp_event_fifo_core;
  import etef_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 1150;
  localparam int SETTLE      = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS  = 30;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic              pop_valid;
    chan_t             out_channel;
    logic              out_level;
    logic [TICK_W-1:0] out_tick;
    seq_t              out_seq;
    logic              edge_stored;
    seq_t              channel_count;
    seq_t              drop_count;
  } ring_result_t;

  typedef struct packed {
    bit                is_cfg;
    bit                cfg_val;
    cmd_t              cmd;
    chan_t             ch;
    logic              lvl;
    logic [TICK_W-1:0] tick;
    bit                typed;
    ring_result_t      want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_data;

  etef_in_if  evt_if();
  etef_out_if res_if();

  edge_timestamp_event_fifo_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .evt      (evt_if),
    .res      (res_if)
  );

  // ring and counter mirror
  logic [TICK_W-1:0] ring_tick [RING_SLOTS];
  chan_t             ring_ch   [RING_SLOTS];
  logic              ring_lvl  [RING_SLOTS];
  seq_t              ring_seq  [RING_SLOTS];
  int                ring_wr;
  int                ring_rd;
  seq_t              chan_seq  [CHANNELS];
  seq_t              drop_total;
  bit                capture_on;

  ring_result_t pending_results [$];
  dir_row_t     dir_rows [22];

  int err_count;
  int cyc_count;
  int n_checked;
  int n_popped;
  int n_drops;
  int n_clears;
  int n_sent;
  int n_counted;
  int hold_reqs;
  bit no_idle;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic ring_result_t predict_step(cmd_t c, chan_t ch, logic lvl,
                                                logic [TICK_W-1:0] t);
    ring_result_t r;
    int nxt;
    bit ch_ok;
    r = '0;
    ch_ok = int'(ch) < CHANNELS;
    case (c)
      CMD_RECORD: begin
        if (capture_on && ch_ok) begin
          chan_seq[ch] = chan_seq[ch] + 1'b1;
          nxt = (ring_wr + 1 >= RING_SLOTS) ? 0 : ring_wr + 1;
          // full ring: seq still advances, event is lost
          if (nxt == ring_rd) begin
            drop_total = drop_total + 1'b1;
            n_drops++;
          end else begin
            ring_tick[ring_wr] = t;
            ring_ch[ring_wr]   = ch;
            ring_lvl[ring_wr]  = lvl;
            ring_seq[ring_wr]  = chan_seq[ch];
            ring_wr = nxt;
            r.edge_stored = 1'b1;
          end
        end
      end
      CMD_POP: begin
        if (ring_rd != ring_wr) begin
          r.pop_valid   = 1'b1;
          r.out_channel = ring_ch[ring_rd];
          r.out_level   = ring_lvl[ring_rd];
          r.out_tick    = ring_tick[ring_rd];
          r.out_seq     = ring_seq[ring_rd];
          ring_rd = (ring_rd + 1 >= RING_SLOTS) ? 0 : ring_rd + 1;
        end
      end
      CMD_CLEAR: begin
        foreach (chan_seq[i]) chan_seq[i] = '0;
        drop_total = '0;
        ring_wr = 0;
        ring_rd = 0;
      end
      default: ;
    endcase
    r.channel_count = ch_ok ? chan_seq[ch] : '0;
    r.drop_count    = drop_total;
    return r;
  endfunction

  function automatic ring_result_t want_res(bit pv, chan_t ch, bit lvl, logic [TICK_W-1:0] t,
                                            seq_t sq, bit stored, seq_t cnt, seq_t drops);
    ring_result_t r;
    r.pop_valid     = pv;
    r.out_channel   = ch;
    r.out_level     = lvl;
    r.out_tick      = t;
    r.out_seq       = sq;
    r.edge_stored   = stored;
    r.channel_count = cnt;
    r.drop_count    = drops;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(bit v);
    dir_row_t d;
    d = '0;
    d.is_cfg  = 1'b1;
    d.cfg_val = v;
    return d;
  endfunction

  function automatic dir_row_t cmd_row(cmd_t c, chan_t ch, logic lvl, logic [TICK_W-1:0] t);
    dir_row_t d;
    d = '0;
    d.cmd  = c;
    d.ch   = ch;
    d.lvl  = lvl;
    d.tick = t;
    return d;
  endfunction

  function automatic dir_row_t chk_row(cmd_t c, chan_t ch, logic lvl, logic [TICK_W-1:0] t,
                                       ring_result_t w);
    dir_row_t d;
    d = cmd_row(c, ch, lvl, t);
    d.typed = 1'b1;
    d.want  = w;
    return d;
  endfunction

  function automatic logic [TICK_W-1:0] rand_tick();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return TICK_MAX;
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch, cycle %0d: %s got %h expected %h", cyc_count, what, got, want);
  endtask

  task automatic send_cmd(cmd_t c, chan_t ch, logic lvl, logic [TICK_W-1:0] t, bit typed,
                          ring_result_t want);
    ring_result_t r;
    while (!no_idle && $urandom_range(99) < 16) begin
      evt_if.valid <= 1'b0;
      @(negedge clk);
    end
    evt_if.valid        <= 1'b1;
    evt_if.cmd          <= c;
    evt_if.edge_channel <= ch;
    evt_if.edge_level   <= lvl;
    evt_if.edge_time    <= t;
    @(posedge clk);
    while (!evt_if.ready) @(posedge clk);
    r = predict_step(c, ch, lvl, t);
    pending_results.push_back(typed ? want : r);
    n_sent++;
    if (c == CMD_CLEAR) n_clears++;
    @(negedge clk);
  endtask

  task automatic send_random(cmd_t c);
    if (n_counted >= RAND_ITEMS) return;
    // edges swallowed by a disabled capture do not count toward the item budget
    if (!(c == CMD_RECORD && !capture_on)) n_counted++;
    send_cmd(c, chan_t'($urandom_range(7)), logic'($urandom_range(1)), rand_tick(), 1'b0, '0);
  endtask

  task automatic quiesce();
    evt_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_capture(bit v);
    quiesce();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    capture_on = v;
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= no_idle || ($urandom_range(99) >= 16);
      end
    end
  end

  always @(posedge clk) begin
    ring_result_t w;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", res_if.pop_valid, 0);
      end else begin
        w = pending_results.pop_front();
        n_checked++;
        if (res_if.pop_valid === 1'b1) n_popped++;
        if (res_if.pop_valid !== w.pop_valid)
          report_mismatch("pop_valid", res_if.pop_valid, w.pop_valid);
        if (res_if.out_channel !== w.out_channel)
          report_mismatch("out_channel", res_if.out_channel, w.out_channel);
        if (res_if.out_level !== w.out_level)
          report_mismatch("out_level", res_if.out_level, w.out_level);
        if (res_if.out_tick !== w.out_tick)
          report_mismatch("out_tick", res_if.out_tick, w.out_tick);
        if (res_if.out_seq !== w.out_seq)
          report_mismatch("out_seq", res_if.out_seq, w.out_seq);
        if (res_if.edge_stored !== w.edge_stored)
          report_mismatch("edge_stored", res_if.edge_stored, w.edge_stored);
        if (res_if.channel_count !== w.channel_count)
          report_mismatch("channel_count", res_if.channel_count, w.channel_count);
        if (res_if.drop_count !== w.drop_count)
          report_mismatch("drop_count", res_if.drop_count, w.drop_count);
      end
    end
  end

  initial begin
    while (cyc_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cyc_count,
             pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int phase;
    int seg_len;
    int kind;
    int pick;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_data            = 1'b0;
    evt_if.valid        = 1'b0;
    evt_if.cmd          = CMD_NOP;
    evt_if.edge_channel = '0;
    evt_if.edge_level   = 1'b0;
    evt_if.edge_time    = '0;
    ring_wr    = 0;
    ring_rd    = 0;
    drop_total = '0;
    capture_on = 1'b0;
    foreach (chan_seq[i]) chan_seq[i] = '0;

    dir_rows = '{
      cfg_row(1'b0),
      // nothing recorded yet, capture off
      chk_row(CMD_POP,    3'd0, 1'b0, '0,       want_res(0, 0, 0, '0, 0, 0, 0, 0)),
      chk_row(CMD_RECORD, 3'd5, 1'b1, TICK_MAX, want_res(0, 0, 0, '0, 0, 0, 0, 0)),
      chk_row(CMD_NOP,    3'd3, 1'b1, '0,       want_res(0, 0, 0, '0, 0, 0, 0, 0)),
      chk_row(CMD_CLEAR,  3'd2, 1'b0, '0,       want_res(0, 0, 0, '0, 0, 0, 0, 0)),
      cfg_row(1'b1),
      chk_row(CMD_RECORD, 3'd0, 1'b0, '0,       want_res(0, 0, 0, '0, 0, 1, 1, 0)),
      chk_row(CMD_RECORD, 3'd7, 1'b1, TICK_MAX, want_res(0, 0, 0, '0, 0, 1, 1, 0)),
      cmd_row(CMD_RECORD, 3'd7, 1'b0, 64'h5555_5555_5555_5555),
      cmd_row(CMD_RECORD, 3'd3, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA),
      chk_row(CMD_POP,    3'd0, 1'b0, '0,       want_res(1, 0, 0, '0, 1, 0, 1, 0)),
      chk_row(CMD_POP,    3'd7, 1'b0, '0,       want_res(1, 7, 1, TICK_MAX, 1, 0, 2, 0)),
      cmd_row(CMD_POP,    3'd7, 1'b1, TICK_MAX),
      cmd_row(CMD_POP,    3'd3, 1'b0, '0),
      // ring drained
      chk_row(CMD_POP,    3'd5, 1'b1, TICK_MAX, want_res(0, 0, 0, '0, 0, 0, 0, 0)),
      cmd_row(CMD_NOP,    3'd7, 1'b0, '0),
      chk_row(CMD_CLEAR,  3'd7, 1'b1, TICK_MAX, want_res(0, 0, 0, '0, 0, 0, 0, 0)),
      chk_row(CMD_RECORD, 3'd7, 1'b1, 64'd1,    want_res(0, 0, 0, '0, 0, 1, 1, 0)),
      chk_row(CMD_POP,    3'd7, 1'b0, '0,       want_res(1, 7, 1, 64'd1, 1, 0, 1, 0)),
      cfg_row(1'b0),
      cmd_row(CMD_RECORD, 3'd7, 1'b0, TICK_MAX),
      cmd_row(CMD_POP,    3'd4, 1'b1, '0)
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        set_capture(dir_rows[i].cfg_val);
      end else begin
        send_cmd(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].lvl, dir_rows[i].tick,
                 dir_rows[i].typed, dir_rows[i].want);
      end
    end

    phase = 0;
    while (n_counted < RAND_ITEMS) begin
      set_capture(phase % 4 != 1);
      no_idle = (phase == 2);
      if (phase == 3) hold_reqs++;
      if (!capture_on) begin
        seg_len = $urandom_range(20, 40);
        repeat (seg_len) send_random(cmd_t'($urandom_range(3)));
      end else begin
        repeat (4) begin
          kind = $urandom_range(99);
          if (kind < 30) begin
            // long record run, then long pop run: can overfill the ring and drain it past empty
            seg_len = $urandom_range(50, 80);
            repeat (seg_len) send_random(CMD_RECORD);
            seg_len = $urandom_range(55, 70);
            repeat (seg_len) send_random(CMD_POP);
          end else if (kind < 80) begin
            seg_len = $urandom_range(20, 40);
            repeat (seg_len) begin
              pick = $urandom_range(99);
              send_random(pick < 50 ? CMD_RECORD : pick < 90 ? CMD_POP :
                          pick < 94 ? CMD_CLEAR : CMD_NOP);
            end
          end else begin
            seg_len = $urandom_range(10, 20);
            repeat (seg_len) send_random(cmd_t'($urandom_range(3)));
          end
        end
      end
      phase++;
    end

    quiesce();
    repeat (SETTLE * 2) @(negedge clk);

    $display("%0d commands, %0d results checked, %0d events popped, %0d edges dropped full",
             n_sent, n_checked, n_popped, n_drops);
    $display("%0d clears, capture toggled over %0d phases, one %0d-cycle result hold-off",
             n_clears, phase, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
